// File: hw/rtl/dynamic_priority_scheduler_top_assert.svh
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef DYNAMIC_PRIORITY_SCHEDULER_TOP_ASSERT_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_TOP_ASSERT_SVH

// consequent must hold in the same cycle
`define DPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dps assertion failed");

// consequent must hold in the next cycle
`define DPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dps assertion failed");

`endif

// File: hw/rtl/dps_pkg.sv
package dps_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int COUNT_W   = 5;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic signed [7:0] PRIO_MIN = 8'sh80;

	typedef struct packed {
		logic [7:0]        id;
		logic [7:0]        ticks;
		logic signed [7:0] prio;
	} entry_t;

	// priority decrement, saturating at the floor
	function automatic logic signed [7:0] prio_dec(input logic signed [7:0] p);
		return (p == PRIO_MIN) ? p : p - 8'sd1;
	endfunction

endpackage

// File: hw/rtl/dps_if.sv
interface dps_in_if;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [3:0]        slot;
	logic [7:0]        proc_id;
	logic [7:0]        run_time;
	logic signed [7:0] prio_value;

	modport source (output valid, operation, slot, proc_id, run_time, prio_value,
		input ready);
	modport sink (input valid, operation, slot, proc_id, run_time, prio_value,
		output ready);
endinterface

interface dps_out_if;
	logic       valid;
	logic       ready;
	logic       ran_valid;
	logic [7:0] ran_id;
	logic [3:0] ran_slot;
	logic [7:0] time_left;
	logic       just_finished;
	logic       all_done;

	modport source (output valid, ran_valid, ran_id, ran_slot, time_left, just_finished,
		all_done, input ready);
	modport sink (input valid, ran_valid, ran_id, ran_slot, time_left, just_finished,
		all_done, output ready);
endinterface

// File: hw/rtl/dps_table.sv
module dps_table #(
	parameter int SLOTS = dps_pkg::SLOTS_DEF,
	localparam int SW = $clog2(SLOTS)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [SW-1:0]   wr_addr,
	input  dps_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [SW-1:0]   rd_addr,
	output dps_pkg::entry_t rd_data
);
	import dps_pkg::*;

	entry_t           ent_mem_q [SLOTS];
	entry_t           rd_q;
	logic [SLOTS-1:0] vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			ent_mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= ent_mem_q[rd_addr];
	end

	// per-entry written flags, an unwritten entry reads as zero time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_comb begin
		rd_data       = rd_q;
		rd_data.ticks = rd_vld_q ? rd_q.ticks : 8'd0;
	end

endmodule

// File: hw/rtl/dps_ctrl.sv
`include "dynamic_priority_scheduler_top_assert.svh"

module dps_ctrl #(
	parameter int SLOTS = dps_pkg::SLOTS_DEF,
	localparam int SW = $clog2(SLOTS),
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	dps_in_if.sink          in_ch,
	dps_out_if.source       out_ch,
	input  logic [CW-1:0]   n_use,
	output logic            wr_en,
	output logic [SW-1:0]   wr_addr,
	output dps_pkg::entry_t wr_data,
	output logic            rd_en,
	output logic [SW-1:0]   rd_addr,
	input  dps_pkg::entry_t rd_data
);
	import dps_pkg::*;

	localparam int AW = (SW > 4) ? SW : 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_WB   = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] rd_idx_q;
	logic          issue_q;
	logic          cmp_s1;
	logic          last_s1;
	logic [SW-1:0] idx_s1;
	logic          found_q;
	logic          multi_q;
	logic [SW-1:0] best_idx_q;
	entry_t        best_q;

	logic       out_vld_q;
	logic       ran_valid_q;
	logic [7:0] ran_id_q;
	logic [3:0] ran_slot_q;
	logic [7:0] time_left_q;
	logic       just_finished_q;
	logic       all_done_q;

	logic          in_acc;
	logic          out_free;
	logic          out_load;
	logic          last_issue;
	logic          nz;
	logic          take;
	logic [AW-1:0] slot_ext;
	logic [AW-1:0] best_ext;
	logic          slot_ok;
	logic          load_wr;
	logic [7:0]    ticks_nxt;
	logic          done_nxt;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_vld_q || out_ch.ready;
	assign out_load    = (state_q == ST_WB) && out_free;

	assign slot_ext = AW'(in_ch.slot);
	assign slot_ok  = int'(in_ch.slot) < SLOTS;
	assign load_wr  = in_acc && (in_ch.operation == OP_LOAD) && slot_ok;

	assign best_ext  = AW'(best_idx_q);
	assign ticks_nxt = best_q.ticks - 8'd1;
	// after the tick nothing is left if no slot was pending, or only the chosen one was and it has finished
	assign done_nxt  = !found_q || (!multi_q && ticks_nxt == 8'd0);

	assign rd_en      = (state_q == ST_SCAN) && issue_q;
	assign rd_addr    = rd_idx_q;
	assign last_issue = (CW'(rd_idx_q) == n_q - CW'(1));

	assign nz   = cmp_s1 && (rd_data.ticks != 8'd0);
	assign take = nz && (!found_q || ($signed(rd_data.prio) > $signed(best_q.prio)));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_ext[SW-1:0];
		wr_data = '{id: in_ch.proc_id, ticks: in_ch.run_time, prio: in_ch.prio_value};
		if (load_wr) begin
			wr_en = 1'b1;
		end else if (out_load && found_q) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_data = '{id: best_q.id, ticks: ticks_nxt, prio: prio_dec(best_q.prio)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			rd_idx_q  <= '0;
			issue_q   <= 1'b0;
			cmp_s1    <= 1'b0;
			last_s1   <= 1'b0;
			found_q   <= 1'b0;
			multi_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			cmp_s1  <= rd_en;
			last_s1 <= rd_en && last_issue;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_ch.operation == OP_TICK) begin
						n_q      <= n_use;
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						multi_q  <= 1'b0;
						issue_q  <= (n_use != '0);
						state_q  <= (n_use == '0) ? ST_WB : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_q) begin
						rd_idx_q <= rd_idx_q + 1'b1;
						if (last_issue)
							issue_q <= 1'b0;
					end
					if (take)
						found_q <= 1'b1;
					if (nz && found_q)
						multi_q <= 1'b1;
					if (cmp_s1 && last_s1)
						state_q <= ST_WB;
				end
				ST_WB: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q <= idx_s1;
			best_q     <= rd_data;
		end
		if (rd_en)
			idx_s1 <= rd_idx_q;
		if (out_load) begin
			ran_valid_q     <= found_q;
			ran_id_q        <= found_q ? best_q.id : 8'd0;
			ran_slot_q      <= found_q ? best_ext[3:0] : 4'd0;
			time_left_q     <= found_q ? ticks_nxt : 8'd0;
			just_finished_q <= found_q && (ticks_nxt == 8'd0);
			all_done_q      <= done_nxt;
		end
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.ran_valid     = ran_valid_q;
	assign out_ch.ran_id        = ran_id_q;
	assign out_ch.ran_slot      = ran_slot_q;
	assign out_ch.time_left     = time_left_q;
	assign out_ch.just_finished = just_finished_q;
	assign out_ch.all_done      = all_done_q;

	`DPS_ASSERT_NOW(a_wb_write_found, wr_en && state_q == ST_WB, found_q)
	`DPS_ASSERT_NOW(a_scan_in_range, rd_en, CW'(rd_idx_q) < n_q)
	`DPS_ASSERT_NOW(a_idle_tick_done, out_load && !found_q, done_nxt)
	`DPS_ASSERT_NEXT(a_tick_busy, in_acc && in_ch.operation == OP_TICK, !in_ch.ready)

endmodule

// File: hw/rtl/dynamic_priority_scheduler_top.sv
// channel    dir   handshake      payload
// in_ch      in    valid/ready    operation, slot, proc_id, run_time, prio_value
// out_ch     out   valid/ready    ran_valid, ran_id, ran_slot, time_left, just_finished,
//                                 all_done
// cfg        in    cfg_we         cfg_wdata = process_count
//
// a load gives no item and leaves the input ready; the next item is accepted right after
// a tick's item follows a read scan of the n slots in use, one entry per cycle, and a write-back;
// n = slots in use (at most SLOTS); when n = 0 the scan is skipped and the tick goes straight to write-back
// reset clears the written flags of all slots at once, so no clearing pass is needed
// a result waiting in the output register does not stall the scan; only write-back waits
module dynamic_priority_scheduler_top #(
	parameter int SLOTS = dps_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dps_in_if.sink                        in_ch,
	dps_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [dps_pkg::COUNT_W-1:0]   cfg_wdata
);
	import dps_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [COUNT_W-1:0] pc_q;
	logic [CW-1:0]      n_use;
	logic               wr_en;
	logic [SW-1:0]      wr_addr;
	entry_t             wr_data;
	logic               rd_en;
	logic [SW-1:0]      rd_addr;
	entry_t             rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= '0;
		else if (cfg_we)
			pc_q <= cfg_wdata;
	end

	// a count beyond the table acts as the full table
	assign n_use = (int'(pc_q) > SLOTS) ? CW'(SLOTS) : CW'(pc_q);

	dps_table #(
		.SLOTS(SLOTS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	dps_ctrl #(
		.SLOTS(SLOTS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.n_use  (n_use),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
